/* src/i2cms_pkg.sv */
package i2cms_pkg;

  // Command opcodes
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Transfer modes
  localparam logic [1:0] MODE_WRITE      = 2'd0;
  localparam logic [1:0] MODE_READ       = 2'd1;
  localparam logic [1:0] MODE_WRITE_READ = 2'd2;

  // Transfer status values
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BUSY   = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_DATAV  = 2'd3;

  // Acknowledge control
  localparam logic [1:0] ACK_KEEP  = 2'd0;
  localparam logic [1:0] ACK_SET   = 2'd1;
  localparam logic [1:0] ACK_CLEAR = 2'd2;

  // Bus engine status codes
  localparam logic [7:0] SC_START     = 8'h08;
  localparam logic [7:0] SC_RSTART    = 8'h10;
  localparam logic [7:0] SC_AW_ACK    = 8'h18;
  localparam logic [7:0] SC_AW_NACK   = 8'h20;
  localparam logic [7:0] SC_DW_ACK    = 8'h28;
  localparam logic [7:0] SC_DW_NACK   = 8'h30;
  localparam logic [7:0] SC_ARB_LOST  = 8'h38;
  localparam logic [7:0] SC_AR_ACK    = 8'h40;
  localparam logic [7:0] SC_AR_NACK   = 8'h48;
  localparam logic [7:0] SC_DR_ACK    = 8'h50;
  localparam logic [7:0] SC_DR_NACK   = 8'h58;

  // Address byte keeps the seven address bits, bit 0 is read/write
  localparam logic [7:0] ADDR_MASK = 8'b11111110;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] status_code;
    logic [7:0] bus_byte;
    logic [6:0] target_address;
    logic [1:0] transfer_mode;
    logic [4:0] send_length;
    logic [4:0] receive_length;
    logic [3:0] buffer_index;
    logic [7:0] buffer_byte;
    logic       last_read;
  } in_item_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] data_out;
    logic       request_start;
    logic       request_stop;
    logic [1:0] ack_control;
    logic       accepted;
    logic [1:0] transfer_status;
    logic [7:0] read_byte;
  } out_item_t;

  // Receive buffer strobes
  typedef struct packed {
    logic wr_en;
    logic clr_en;
  } rx_ctl_t;

endpackage

/* src/i2c_master_status_sequencer.sv */
// I2C master sequencer driven by bus engine status codes.
// Input channel (in_valid / in_stall / in_item) carries one command per
// transfer: a bus status event, a transmit byte load, a transfer start or a
// received byte read. The result channel (out_valid / out_stall / out_item)
// returns exactly one result per command, in command order.
// A command passes through two register stages, the command register and
// the result register. Throughput: one command per cycle while the receiver
// does not stall; the decode and the state update happen combinationally
// between the two registers.
// When the receiver stalls, the result register holds; one more command
// waits in the command register, then in_stall rises until the result is
// taken. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties both registers, sets the status to
// idle, clears positions, counts and the address byte, and marks all receive
// slots empty (they read as zero). Transmit slots hold no reset value and
// should be loaded before they are sent.
module i2c_master_status_sequencer #(
  parameter int SEND_DEPTH    = 16,
  parameter int RECEIVE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  i2cms_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output i2cms_pkg::out_item_t  out_item
);
  import i2cms_pkg::*;

  localparam int POS_MAX = (SEND_DEPTH > RECEIVE_DEPTH) ? SEND_DEPTH : RECEIVE_DEPTH;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int SCNT_W  = $clog2(SEND_DEPTH + 1);
  localparam int RCNT_W  = $clog2(RECEIVE_DEPTH + 1);
  localparam int CW      = ((POS_W > 5) ? POS_W : 5) + 1;
  localparam int SIDX_W  = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int RIDX_W  = $clog2(RECEIVE_DEPTH);

  localparam logic [CW-1:0] POS_MAX_C = CW'(POS_MAX);
  localparam logic [CW-1:0] SDEPTH_C  = CW'(SEND_DEPTH);
  localparam logic [CW-1:0] RDEPTH_C  = CW'(RECEIVE_DEPTH);
  localparam logic [CW-1:0] ONE_C     = CW'(1);

  // Pipeline registers
  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      advance;

  // Sequencer state
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [7:0]        addr_r,   addr_nxt;
  logic [SCNT_W-1:0] scnt_r,   scnt_nxt;
  logic [RCNT_W-1:0] rcnt_r,   rcnt_nxt;
  logic              raw_r,    raw_nxt;
  logic [1:0]        status_r, status_nxt;

  logic [7:0] send_mem_r [SEND_DEPTH];

  // Decode helpers
  logic [CW-1:0]     pos_c, pos_inc, spos, sidx_c, idx_c, slen_c, rlen_c;
  logic [7:0]        send_rd;
  logic [7:0]        rx_rd;
  rx_ctl_t           rx_ctl;
  logic [RIDX_W-1:0] rx_wr_addr;
  logic [RIDX_W-1:0] rx_rd_addr;
  logic              send_wr;

  // Handshake: the command register moves on whenever the result register
  // is empty or being drained
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Position, index and length arithmetic
  always_comb begin
    pos_c   = CW'(pos_r);
    pos_inc = (pos_c < POS_MAX_C) ? pos_c + ONE_C : pos_c;
    spos    = (in_item_r.status_code == SC_DW_ACK) ? pos_inc : pos_c;
    sidx_c  = (spos >= SDEPTH_C) ? SDEPTH_C - ONE_C : spos;
    idx_c   = CW'(in_item_r.buffer_index);
    slen_c  = CW'(in_item_r.send_length);
    rlen_c  = CW'(in_item_r.receive_length);
  end

  assign send_rd    = send_mem_r[SIDX_W'(sidx_c)];
  assign rx_wr_addr = RIDX_W'(pos_r);
  assign rx_rd_addr = RIDX_W'(in_item_r.buffer_index);

  // Command decode and state update
  always_comb begin
    pos_nxt      = pos_r;
    addr_nxt     = addr_r;
    scnt_nxt     = scnt_r;
    rcnt_nxt     = rcnt_r;
    raw_nxt      = raw_r;
    status_nxt   = status_r;
    out_item_nxt = '0;
    rx_ctl       = '0;
    send_wr      = 1'b0;

    case (in_item_r.opcode)
      OP_EVENT: begin
        case (in_item_r.status_code)
          SC_START, SC_RSTART: begin
            out_item_nxt.load_data = 1'b1;
            out_item_nxt.data_out  = addr_r;
          end
          SC_AW_ACK: begin
            out_item_nxt.load_data = 1'b1;
            out_item_nxt.data_out  = send_rd;
          end
          SC_AW_NACK, SC_AR_NACK: begin
            out_item_nxt.request_stop = 1'b1;
            status_nxt = ST_FAILED;
            pos_nxt    = '0;
          end
          SC_DW_ACK: begin
            // write phase ends once every byte has gone out
            if (pos_inc >= CW'(scnt_r)) begin
              if (raw_r) begin
                out_item_nxt.request_start = 1'b1;
                addr_nxt = addr_r | 8'h01;
              end else begin
                out_item_nxt.request_stop = 1'b1;
                status_nxt = ST_IDLE;
              end
              pos_nxt = '0;
            end else begin
              out_item_nxt.load_data = 1'b1;
              out_item_nxt.data_out  = send_rd;
              pos_nxt = POS_W'(pos_inc);
            end
          end
          SC_DW_NACK: begin
            out_item_nxt.request_stop = 1'b1;
            status_nxt = ST_IDLE;
            pos_nxt    = '0;
          end
          SC_ARB_LOST: begin
            pos_nxt = '0;
          end
          SC_AR_ACK: begin
            out_item_nxt.ack_control = ACK_SET;
          end
          SC_DR_ACK: begin
            rx_ctl.wr_en = advance && (pos_c < RDEPTH_C);
            pos_nxt      = POS_W'(pos_inc);
            // NACK the next byte when it is the last one
            out_item_nxt.ack_control =
              ((pos_inc + ONE_C) >= CW'(rcnt_r)) ? ACK_CLEAR : ACK_SET;
          end
          SC_DR_NACK: begin
            rx_ctl.wr_en = advance && (pos_c < RDEPTH_C);
            out_item_nxt.request_stop = 1'b1;
            status_nxt = ST_DATAV;
            pos_nxt    = '0;
          end
          default: begin
          end
        endcase
      end
      OP_LOAD: begin
        send_wr = advance && (idx_c < SDEPTH_C);
      end
      OP_START: begin
        if (status_r != ST_BUSY && status_r != ST_DATAV) begin
          addr_nxt = ({in_item_r.target_address, 1'b0} & ADDR_MASK)
                   | {7'd0, in_item_r.transfer_mode[0]};
          scnt_nxt = (slen_c > SDEPTH_C) ? SCNT_W'(SEND_DEPTH) : SCNT_W'(slen_c);
          rcnt_nxt = (rlen_c > RDEPTH_C) ? RCNT_W'(RECEIVE_DEPTH) : RCNT_W'(rlen_c);
          raw_nxt  = (in_item_r.transfer_mode == MODE_WRITE_READ);
          status_nxt = ST_BUSY;
          out_item_nxt.request_start = 1'b1;
          out_item_nxt.accepted      = 1'b1;
        end
      end
      OP_READ: begin
        if (status_r == ST_DATAV) begin
          out_item_nxt.accepted = 1'b1;
          if (idx_c < RDEPTH_C) begin
            out_item_nxt.read_byte = rx_rd;
            rx_ctl.clr_en = advance;
          end
        end
        if (in_item_r.last_read) begin
          status_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    out_item_nxt.transfer_status = status_nxt;
  end

  // Receive buffer
  i2cms_rx_store #(
    .DEPTH (RECEIVE_DEPTH),
    .IDX_W (RIDX_W)
  ) u_rx_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rx_ctl),
    .wr_addr (rx_wr_addr),
    .wr_data (in_item_r.bus_byte),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd)
  );

  // Control registers and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      addr_r      <= '0;
      scnt_r      <= '0;
      rcnt_r      <= '0;
      raw_r       <= 1'b0;
      status_r    <= ST_IDLE;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        addr_r      <= addr_nxt;
        scnt_r      <= scnt_nxt;
        rcnt_r      <= rcnt_nxt;
        raw_r       <= raw_nxt;
        status_r    <= status_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Transmit buffer
  always_ff @(posedge clk) begin
    if (send_wr) begin
      send_mem_r[SIDX_W'(in_item_r.buffer_index)] <= in_item_r.buffer_byte;
    end
  end

  // Checks
  a_busy_only_by_start: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && status_r != ST_BUSY && status_nxt == ST_BUSY)
      |-> (in_item_r.opcode == OP_START))
    else $error("status went busy without a start command");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(pos_r) <= POS_MAX_C)
    else $error("byte position past its limit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(scnt_r) <= SDEPTH_C) && (CW'(rcnt_r) <= RDEPTH_C))
    else $error("byte count past buffer depth");

  a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without a command");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(status_r) && $stable(pos_r))
    else $error("state changed without a command");

endmodule

/* src/i2cms_rx_store.sv */
module i2cms_rx_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cms_pkg::rx_ctl_t   ctl,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [7:0]           wr_data,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [7:0]           rd_data
);
  import i2cms_pkg::*;

  logic [7:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;

  // An entry that is not valid reads as zero
  assign rd_data = vld_r[rd_addr] ? mem_r[rd_addr] : 8'h00;

  // Valid bits: set on a received byte, cleared when the byte is read out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ctl.clr_en) begin
        vld_r[rd_addr] <= 1'b0;
      end
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Data storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

endmodule
